@@ rtl/core/oahi_pkg.sv @@
// shared types, codes and defaults of the open-addressing hash insert block
// no dependencies; used by every file in rtl/core but oahi_ram
package oahi_pkg;

    localparam int DEPTH_DEF    = 64;
    localparam int KEY_BITS_DEF = 16;

    localparam int MODE_W     = 2;
    localparam int TSIZE_W    = 7;
    localparam int COEF_W     = 4;
    localparam int SLOT_W     = 6;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    // every residue is below the table size, so it fits the table size width
    localparam int VAL_W      = TSIZE_W;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [VAL_W:0]   t_sum;
    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROBE_MODE = 2'd0,
        CFG_TABLE_SIZE = 2'd1,
        CFG_QUAD_C1    = 2'd2,
        CFG_QUAD_C2    = 2'd3
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_LINEAR = 2'd0,
        MODE_QUAD   = 2'd1,
        MODE_DOUBLE = 2'd2
    } t_probe_mode;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [MODE_W-1:0]  PROBE_MODE_RST = 2'd0;
    localparam logic [TSIZE_W-1:0] TSIZE_RST      = 7'd11;
    localparam logic [COEF_W-1:0]  QUAD_C1_RST    = 4'd1;
    localparam logic [COEF_W-1:0]  QUAD_C2_RST    = 4'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_PROBE_RD,
        ST_PROBE_CHK,
        ST_STEP_UPD,
        ST_READ_RD,
        ST_READ_CHK,
        ST_DONE
    } t_state;

    // which residue the shared unit is working out
    typedef enum logic [1:0] {
        PH_KEY,
        PH_DBL,
        PH_QD,
        PH_QE
    } t_phase;

endpackage

@@ rtl/core/oahi_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module oahi_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/oahi_addmod.sv @@
// shared modular add unit: (a + b) mod m for a, b below m, one subtract
// depends on oahi_pkg
module oahi_addmod (
    input  oahi_pkg::t_val i_a,
    input  oahi_pkg::t_val i_b,
    input  oahi_pkg::t_val i_m,
    output oahi_pkg::t_val o_y
);

    oahi_pkg::t_sum sum;
    oahi_pkg::t_sum diff;

    assign sum  = {1'b0, i_a} + {1'b0, i_b};
    assign diff = sum - {1'b0, i_m};
    assign o_y  = (sum >= {1'b0, i_m}) ? oahi_pkg::t_val'(diff) : oahi_pkg::t_val'(sum);

endmodule

@@ rtl/core/open_addressing_hash_insert.sv @@
// open-addressing hash table: insert with linear, quadratic or double probing, slot read
// depends on oahi_pkg, oahi_ram, oahi_addmod
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+------------------------------------------
//  in       | in        | i_in_valid / o_in_ready  | i_cmd i_key i_slot_index i_batch_last
//  out      | out       | o_out_valid / i_out_ready| o_slot o_probe_count o_placed
//           |           |                          | o_stored_key o_slot_valid o_batch_done
//  cfg      | in        | i_cfg_valid / o_cfg_ready| i_cfg_index i_cfg_data
//
//  one word at a time; a read goes through a ram read, a check and the done state to the output register
//  an insert works out each residue in W = max(KEY_BITS,5) bit steps of the shared modular
//  adder (R = 1 residue linear, 2 double, 3 quadratic), then probes, each one ram read and
//  one check, with one step update on the adder between probes in quadratic mode
//  after reset a clearing pass writes every ram word empty, input not ready
//  a finished word waits in the output register; the next word is taken meanwhile and held
//  back at the end only if the output register is still occupied
//  cfg writes are always taken and must only come while the block is idle
module open_addressing_hash_insert #(
    parameter int DEPTH    = oahi_pkg::DEPTH_DEF,
    parameter int KEY_BITS = oahi_pkg::KEY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [KEY_BITS-1:0]             i_key,
    input  logic [oahi_pkg::SLOT_W-1:0]     i_slot_index,
    input  logic                            i_batch_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [oahi_pkg::SLOT_W-1:0]     o_slot,
    output logic [oahi_pkg::CNT_W-1:0]      o_probe_count,
    output logic                            o_placed,
    output logic [KEY_BITS-1:0]             o_stored_key,
    output logic                            o_slot_valid,
    output logic                            o_batch_done,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [oahi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [oahi_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int AW   = $clog2(DEPTH);
    localparam int DW   = (KEY_BITS > 5) ? KEY_BITS : 5;
    localparam int BW   = $clog2(DW + 1);
    localparam int NMAX = (DEPTH < 127) ? DEPTH : 127;
    localparam int RW   = KEY_BITS + 1;

    oahi_pkg::t_state r_state, n_state;
    oahi_pkg::t_phase r_phase, n_phase;

    logic [oahi_pkg::MODE_W-1:0]  r_probe_mode;
    logic [oahi_pkg::TSIZE_W-1:0] r_tsize;
    logic [oahi_pkg::COEF_W-1:0]  r_c1, r_c2;

    logic                r_cmd;
    logic [KEY_BITS-1:0] r_key;
    oahi_pkg::t_slot     r_idx;
    logic                r_last;

    oahi_pkg::t_val  r_s, n_s, r_d, n_d, r_e, n_e, r_acc, n_acc;
    logic [DW-1:0]   r_div, n_div;
    logic [BW-1:0]   r_bit, n_bit;
    oahi_pkg::t_cnt  r_cnt, n_cnt;
    logic [AW-1:0]   r_clr, n_clr;

    oahi_pkg::t_slot     r_res_slot, n_res_slot;
    oahi_pkg::t_cnt      r_res_cnt, n_res_cnt;
    logic                r_res_placed, n_res_placed;
    logic [KEY_BITS-1:0] r_res_key, n_res_key;
    logic                r_res_valid, n_res_valid;

    logic                r_out_valid;
    oahi_pkg::t_slot     r_out_slot;
    oahi_pkg::t_cnt      r_out_cnt;
    logic                r_out_placed;
    logic [KEY_BITS-1:0] r_out_key;
    logic                r_out_slot_valid;
    logic                r_out_last;

    oahi_pkg::t_val u_a, u_b, u_m, u_y;
    oahi_pkg::t_val eff_n;
    oahi_pkg::t_cnt cnt1;

    logic            in_acc, out_load, mod_last, is_quad, is_dbl, idx_ok;
    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [RW-1:0]   ram_wdata, ram_q;

    // effective table size, clamped to 2 .. DEPTH, and to 127 at most
    always_comb begin
        if (r_tsize < 7'd2) begin
            eff_n = 7'd2;
        end else if (r_tsize > 7'(NMAX)) begin
            eff_n = 7'(NMAX);
        end else begin
            eff_n = r_tsize;
        end
    end

    assign is_quad  = (r_probe_mode == oahi_pkg::MODE_QUAD);
    assign is_dbl   = (r_probe_mode == oahi_pkg::MODE_DOUBLE);
    assign mod_last = (r_bit == BW'(1));
    assign cnt1     = r_cnt + 7'd1;
    assign idx_ok   = (int'(r_idx) < DEPTH);
    assign in_acc   = i_in_valid && o_in_ready;
    assign out_load = (r_state == oahi_pkg::ST_DONE) && (!r_out_valid || i_out_ready);

    assign o_in_ready  = (r_state == oahi_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;

    oahi_addmod u_addmod (
        .i_a (u_a),
        .i_b (u_b),
        .i_m (u_m),
        .o_y (u_y)
    );

    oahi_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_q)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            oahi_pkg::ST_CLEAR: begin
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = oahi_pkg::ST_IDLE;
                end
            end
            oahi_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = (i_cmd == oahi_pkg::CMD_READ) ? oahi_pkg::ST_READ_RD
                                                            : oahi_pkg::ST_MOD;
                end
            end
            oahi_pkg::ST_MOD: begin
                if (mod_last) begin
                    unique case (r_phase)
                        oahi_pkg::PH_KEY: begin
                            n_state = (is_quad || is_dbl) ? oahi_pkg::ST_MOD
                                                          : oahi_pkg::ST_PROBE_RD;
                        end
                        oahi_pkg::PH_QD:  n_state = oahi_pkg::ST_MOD;
                        oahi_pkg::PH_DBL: n_state = oahi_pkg::ST_PROBE_RD;
                        oahi_pkg::PH_QE:  n_state = oahi_pkg::ST_PROBE_RD;
                        default:          n_state = oahi_pkg::ST_PROBE_RD;
                    endcase
                end
            end
            oahi_pkg::ST_PROBE_RD: n_state = oahi_pkg::ST_PROBE_CHK;
            oahi_pkg::ST_PROBE_CHK: begin
                priority if (!ram_q[KEY_BITS] || cnt1 == eff_n) begin
                    n_state = oahi_pkg::ST_DONE;
                end else if (is_quad) begin
                    n_state = oahi_pkg::ST_STEP_UPD;
                end else begin
                    n_state = oahi_pkg::ST_PROBE_RD;
                end
            end
            oahi_pkg::ST_STEP_UPD: n_state = oahi_pkg::ST_PROBE_RD;
            oahi_pkg::ST_READ_RD:  n_state = oahi_pkg::ST_READ_CHK;
            oahi_pkg::ST_READ_CHK: n_state = oahi_pkg::ST_DONE;
            oahi_pkg::ST_DONE: begin
                if (out_load) begin
                    n_state = oahi_pkg::ST_IDLE;
                end
            end
            default: n_state = oahi_pkg::ST_IDLE;
        endcase
    end

    // datapath control and next values
    always_comb begin
        n_phase      = r_phase;
        n_s          = r_s;
        n_d          = r_d;
        n_e          = r_e;
        n_acc        = r_acc;
        n_div        = r_div;
        n_bit        = r_bit;
        n_cnt        = r_cnt;
        n_clr        = r_clr;
        n_res_slot   = r_res_slot;
        n_res_cnt    = r_res_cnt;
        n_res_placed = r_res_placed;
        n_res_key    = r_res_key;
        n_res_valid  = r_res_valid;
        u_a          = '0;
        u_b          = '0;
        u_m          = eff_n;
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_s);
        ram_wdata    = {1'b1, r_key};
        ram_re       = 1'b0;
        ram_raddr    = AW'(r_s);
        unique case (r_state)
            oahi_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + AW'(1);
            end
            oahi_pkg::ST_IDLE: begin
                n_cnt   = '0;
                n_acc   = '0;
                n_div   = DW'(i_key);
                n_bit   = BW'(DW);
                n_phase = oahi_pkg::PH_KEY;
            end
            oahi_pkg::ST_MOD: begin
                // restoring remainder, one dividend bit a step
                u_a   = r_acc;
                u_b   = r_acc + 7'(r_div[DW-1]);
                u_m   = (r_phase == oahi_pkg::PH_DBL) ? (eff_n - 7'd1) : eff_n;
                n_acc = u_y;
                n_div = r_div << 1;
                n_bit = r_bit - BW'(1);
                if (mod_last) begin
                    n_acc = '0;
                    n_bit = BW'(DW);
                    unique case (r_phase)
                        oahi_pkg::PH_KEY: begin
                            n_s = u_y;
                            n_d = 7'd1;
                            n_e = '0;
                            if (is_quad) begin
                                n_phase = oahi_pkg::PH_QD;
                                n_div   = DW'({1'b0, r_c1} + {1'b0, r_c2});
                            end else if (is_dbl) begin
                                n_phase = oahi_pkg::PH_DBL;
                                n_div   = DW'(r_key);
                            end
                        end
                        oahi_pkg::PH_DBL: n_d = u_y + 7'd1;
                        oahi_pkg::PH_QD: begin
                            // first quadratic step c1 + c2, later ones grow by 2*c2
                            n_d     = u_y;
                            n_phase = oahi_pkg::PH_QE;
                            n_div   = DW'({r_c2, 1'b0});
                        end
                        oahi_pkg::PH_QE: n_e = u_y;
                        default: n_e = '0;
                    endcase
                end
            end
            oahi_pkg::ST_PROBE_RD: begin
                ram_re = 1'b1;
            end
            oahi_pkg::ST_PROBE_CHK: begin
                u_a = r_s;
                u_b = r_d;
                if (!ram_q[KEY_BITS]) begin
                    ram_we       = 1'b1;
                    n_res_slot   = oahi_pkg::t_slot'(r_s);
                    n_res_cnt    = cnt1;
                    n_res_placed = 1'b1;
                    n_res_key    = r_key;
                    n_res_valid  = 1'b1;
                end else if (cnt1 == eff_n) begin
                    // table full within the probe budget
                    n_res_slot   = '0;
                    n_res_cnt    = cnt1;
                    n_res_placed = 1'b0;
                    n_res_key    = '0;
                    n_res_valid  = 1'b0;
                end else begin
                    n_s   = u_y;
                    n_cnt = cnt1;
                end
            end
            oahi_pkg::ST_STEP_UPD: begin
                u_a = r_d;
                u_b = r_e;
                n_d = u_y;
            end
            oahi_pkg::ST_READ_RD: begin
                ram_re    = 1'b1;
                ram_raddr = AW'(r_idx);
            end
            oahi_pkg::ST_READ_CHK: begin
                n_res_slot   = r_idx;
                n_res_cnt    = '0;
                n_res_placed = 1'b0;
                n_res_valid  = idx_ok && ram_q[KEY_BITS];
                n_res_key    = (idx_ok && ram_q[KEY_BITS]) ? ram_q[KEY_BITS-1:0] : '0;
            end
            oahi_pkg::ST_DONE: begin
                n_cnt = r_cnt;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= oahi_pkg::ST_CLEAR;
            r_clr        <= '0;
            r_out_valid  <= 1'b0;
            r_probe_mode <= oahi_pkg::PROBE_MODE_RST;
            r_tsize      <= oahi_pkg::TSIZE_RST;
            r_c1         <= oahi_pkg::QUAD_C1_RST;
            r_c2         <= oahi_pkg::QUAD_C2_RST;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (oahi_pkg::t_cfg_idx'(i_cfg_index))
                    oahi_pkg::CFG_PROBE_MODE: r_probe_mode <= i_cfg_data[1:0];
                    oahi_pkg::CFG_TABLE_SIZE: r_tsize      <= i_cfg_data;
                    oahi_pkg::CFG_QUAD_C1:    r_c1         <= i_cfg_data[3:0];
                    oahi_pkg::CFG_QUAD_C2:    r_c2         <= i_cfg_data[3:0];
                    default:                  r_c2         <= r_c2;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cmd  <= i_cmd;
            r_key  <= i_key;
            r_idx  <= i_slot_index;
            r_last <= i_batch_last;
        end
        r_phase      <= n_phase;
        r_s          <= n_s;
        r_d          <= n_d;
        r_e          <= n_e;
        r_acc        <= n_acc;
        r_div        <= n_div;
        r_bit        <= n_bit;
        r_cnt        <= n_cnt;
        r_res_slot   <= n_res_slot;
        r_res_cnt    <= n_res_cnt;
        r_res_placed <= n_res_placed;
        r_res_key    <= n_res_key;
        r_res_valid  <= n_res_valid;
        if (out_load) begin
            r_out_slot       <= r_res_slot;
            r_out_cnt        <= r_res_cnt;
            r_out_placed     <= r_res_placed && (r_cmd == oahi_pkg::CMD_INSERT);
            r_out_key        <= r_res_key;
            r_out_slot_valid <= r_res_valid;
            r_out_last       <= r_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_slot        = r_out_slot;
    assign o_probe_count = r_out_cnt;
    assign o_placed      = r_out_placed;
    assign o_stored_key  = r_out_key;
    assign o_slot_valid  = r_out_slot_valid;
    assign o_batch_done  = r_out_last;

endmodule

@@ rtl/core/oahi_check.sv @@
// port-level checker for open_addressing_hash_insert, bound to the top level
// depends on oahi_pkg and open_addressing_hash_insert
module oahi_check #(
    parameter int KEY_BITS = oahi_pkg::KEY_BITS_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input logic                            i_cmd,
    input logic [KEY_BITS-1:0]             i_key,
    input logic [oahi_pkg::SLOT_W-1:0]     i_slot_index,
    input logic                            i_batch_last,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic [oahi_pkg::SLOT_W-1:0]     o_slot,
    input logic [oahi_pkg::CNT_W-1:0]      o_probe_count,
    input logic                            o_placed,
    input logic [KEY_BITS-1:0]             o_stored_key,
    input logic                            o_slot_valid,
    input logic                            o_batch_done,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [oahi_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [oahi_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // no word comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");

    // a placed key is always stored and took at least one probe
    a_placed_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_placed) |-> (o_slot_valid && o_probe_count != 7'd0))
        else $error("placed word without stored key or probe");

    // a failed insert shows an empty slot zero
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_placed && o_probe_count != 7'd0)
            |-> (!o_slot_valid && o_slot == 6'd0 && o_stored_key == '0))
        else $error("failed insert word not cleared");

    // empty slot reads as key zero
    a_empty_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_slot_valid) |-> (o_stored_key == '0))
        else $error("empty slot with nonzero key");

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready)
            |=> (o_out_valid && $stable(o_slot) && $stable(o_stored_key)))
        else $error("stalled output word changed");

endmodule

bind open_addressing_hash_insert oahi_check #(.KEY_BITS(KEY_BITS)) u_oahi_check (.*);

@@ tb/sv/oahi_checker.sv @@
// result checker for open_addressing_hash_insert: follows the table contents and config
// from the accepted words and compares every output word with its prediction; needs oahi_pkg
`timescale 1ns / 1ps

module oahi_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_cmd,
    input  logic [oahi_pkg::KEY_BITS_DEF-1:0]   i_key,
    input  logic [oahi_pkg::SLOT_W-1:0]         i_slot_index,
    input  logic                                i_batch_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [oahi_pkg::SLOT_W-1:0]         i_slot,
    input  logic [oahi_pkg::CNT_W-1:0]          i_probe_count,
    input  logic                                i_placed,
    input  logic [oahi_pkg::KEY_BITS_DEF-1:0]   i_stored_key,
    input  logic                                i_slot_valid,
    input  logic                                i_batch_done,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [oahi_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [oahi_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import oahi_pkg::*;

    typedef struct packed {
        t_slot                   slot;
        t_cnt                    probe_count;
        logic                    placed;
        logic [KEY_BITS_DEF-1:0] stored_key;
        logic                    slot_valid;
        logic                    batch_done;
    } t_slot_result;

    logic [MODE_W-1:0]       mode_q;
    logic [TSIZE_W-1:0]      tsize_q;
    logic [COEF_W-1:0]       c1_q;
    logic [COEF_W-1:0]       c2_q;
    logic [KEY_BITS_DEF-1:0] table_keys [DEPTH_DEF];
    logic                    table_used [DEPTH_DEF];

    t_slot_result slot_results [$];
    t_slot_result want;
    t_slot_result fresh;

    function automatic int probe_target(longint k, longint i, longint n);
        longint off;
        case (mode_q)
            MODE_QUAD:   off = longint'(c1_q) * i + longint'(c2_q) * i * i;
            MODE_DOUBLE: off = i * (1 + k % (n - 1));
            default:     off = i;
        endcase
        return int'((k + off) % n);
    endfunction

    task automatic hash_table_step(input logic cmd_in, input logic [KEY_BITS_DEF-1:0] key_in,
                                   input t_slot idx, input logic last,
                                   output t_slot_result r);
        int n;
        int s;
        r = '0;
        r.batch_done = last;
        if (cmd_in == CMD_INSERT) begin
            n = int'(tsize_q);
            if (n < 2) n = 2;
            if (n > DEPTH_DEF) n = DEPTH_DEF;
            // a full table leaves slot 0, key 0 and a count equal to the size
            for (int i = 0; i < n; i++) begin
                s = probe_target(longint'(key_in), i, n);
                r.probe_count = t_cnt'(i + 1);
                if (!table_used[s]) begin
                    table_used[s] = 1'b1;
                    table_keys[s] = key_in;
                    r.slot        = t_slot'(s);
                    r.placed      = 1'b1;
                    r.stored_key  = key_in;
                    r.slot_valid  = 1'b1;
                    break;
                end
            end
        end else begin
            r.slot = idx;
            if (table_used[idx]) begin
                r.stored_key = table_keys[idx];
                r.slot_valid = 1'b1;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q  = PROBE_MODE_RST;
            tsize_q = TSIZE_RST;
            c1_q    = QUAD_C1_RST;
            c2_q    = QUAD_C2_RST;
            for (int j = 0; j < DEPTH_DEF; j++) table_used[j] = 1'b0;
            slot_results.delete();
            o_fail_count = 0;
            o_pending    = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (slot_results.size() == 0) begin
                    $error("output word with no expectation pending: slot %0d", i_slot);
                    o_fail_count++;
                end else begin
                    want = slot_results.pop_front();
                    if (i_slot != want.slot) begin
                        $error("slot: expected %0d, actual %0d", want.slot, i_slot);
                        o_fail_count++;
                    end
                    if (i_probe_count != want.probe_count) begin
                        $error("probe_count: expected %0d, actual %0d",
                               want.probe_count, i_probe_count);
                        o_fail_count++;
                    end
                    if (i_placed != want.placed) begin
                        $error("placed: expected %0d, actual %0d", want.placed, i_placed);
                        o_fail_count++;
                    end
                    if (i_stored_key != want.stored_key) begin
                        $error("stored_key: expected %0d, actual %0d",
                               want.stored_key, i_stored_key);
                        o_fail_count++;
                    end
                    if (i_slot_valid != want.slot_valid) begin
                        $error("slot_valid: expected %0d, actual %0d",
                               want.slot_valid, i_slot_valid);
                        o_fail_count++;
                    end
                    if (i_batch_done != want.batch_done) begin
                        $error("batch_done: expected %0d, actual %0d",
                               want.batch_done, i_batch_done);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROBE_MODE: mode_q  = i_cfg_data[MODE_W-1:0];
                    CFG_TABLE_SIZE: tsize_q = i_cfg_data[TSIZE_W-1:0];
                    CFG_QUAD_C1:    c1_q    = i_cfg_data[COEF_W-1:0];
                    CFG_QUAD_C2:    c2_q    = i_cfg_data[COEF_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                hash_table_step(i_cmd, i_key, i_slot_index, i_batch_last, fresh);
                slot_results.push_back(fresh);
            end
            o_pending = slot_results.size();
        end
    end

endmodule

@@ tb/sv/open_addressing_hash_insert_tb.sv @@
// top of the open_addressing_hash_insert testbench: clock, reset, directed and random words,
// config phases and the verdict; needs oahi_pkg, oahi_checker and the block itself
`timescale 1ns / 1ps

module open_addressing_hash_insert_tb;
    import oahi_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 300;
    localparam int PHASE_WORDS  = 110;
    localparam int NPHASE       = 12;
    // the fourth mode code has no name in the package and behaves as linear
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic                    cmd;
    logic [KEY_BITS_DEF-1:0] key;
    t_slot                   slot_index;
    logic                    batch_last;
    logic                    out_valid;
    logic                    out_ready;
    t_slot                   slot;
    t_cnt                    probe_count;
    logic                    placed;
    logic [KEY_BITS_DEF-1:0] stored_key;
    logic                    slot_valid;
    logic                    batch_done;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    int                      fail_count;
    int                      pending;

    int                      send_idle_pct = 0;
    int                      stall_pct = 0;
    int                      cur_size = 11;
    logic [KEY_BITS_DEF-1:0] recent_key = '0;

    logic [MODE_W-1:0]  setting_mode [NPHASE] = '{
        MODE_LINEAR, MODE_QUAD, MODE_DOUBLE, MODE_QUAD, MODE_LINEAR, MODE_DOUBLE,
        MODE_QUAD, MODE_SPARE, MODE_DOUBLE, MODE_QUAD, MODE_LINEAR, MODE_DOUBLE
    };
    logic [TSIZE_W-1:0] setting_size [NPHASE] = '{
        7'd5, 7'd13, 7'd16, 7'd17, 7'd1, 7'd2, 7'd32, 7'd40, 7'd64, 7'd64, 7'd100, 7'd37
    };
    logic [COEF_W-1:0]  setting_c1 [NPHASE] = '{
        4'd1, 4'd0, 4'd1, 4'd15, 4'd1, 4'd5, 4'd2, 4'd1, 4'd0, 4'd7, 4'd3, 4'd15
    };
    logic [COEF_W-1:0]  setting_c2 [NPHASE] = '{
        4'd3, 4'd0, 4'd3, 4'd15, 4'd3, 4'd10, 4'd1, 4'd3, 4'd15, 4'd9, 4'd3, 4'd0
    };

    open_addressing_hash_insert dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_cmd         (cmd),
        .i_key         (key),
        .i_slot_index  (slot_index),
        .i_batch_last  (batch_last),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_slot        (slot),
        .o_probe_count (probe_count),
        .o_placed      (placed),
        .o_stored_key  (stored_key),
        .o_slot_valid  (slot_valid),
        .o_batch_done  (batch_done),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    oahi_checker chk (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_cmd         (cmd),
        .i_key         (key),
        .i_slot_index  (slot_index),
        .i_batch_last  (batch_last),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_slot        (slot),
        .i_probe_count (probe_count),
        .i_placed      (placed),
        .i_stored_key  (stored_key),
        .i_slot_valid  (slot_valid),
        .i_batch_done  (batch_done),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // entered and left at a falling edge; valid stays up between back-to-back words
    task automatic send_word(input logic c, input logic [KEY_BITS_DEF-1:0] k,
                             input t_slot idx, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        key        <= k;
        slot_index <= idx;
        batch_last <= last;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [MODE_W-1:0] mode, input logic [TSIZE_W-1:0] size,
                                  input logic [COEF_W-1:0] c1, input logic [COEF_W-1:0] c2);
        logic [CFG_DATA_W-1:0] noise;
        // every result is back before the registers change
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        noise = CFG_DATA_W'($urandom);
        write_cfg(CFG_PROBE_MODE, {noise[6:2], mode});
        write_cfg(CFG_TABLE_SIZE, size);
        noise = CFG_DATA_W'($urandom);
        write_cfg(CFG_QUAD_C1, {noise[6:4], c1});
        noise = CFG_DATA_W'($urandom);
        write_cfg(CFG_QUAD_C2, {noise[6:4], c2});
        cfg_valid <= 1'b0;
        cur_size = (size < 2) ? 2 : (size > DEPTH_DEF) ? DEPTH_DEF : int'(size);
    endtask

    // batches of inserts closed by batch_last, then a few reads; now and then a stray word
    task automatic random_phase(input int words);
        int sent;
        int batch_len;
        int reads;
        logic [KEY_BITS_DEF-1:0] k;
        sent = 0;
        while (sent < words) begin
            if ($urandom_range(9) == 0) begin
                send_word(1'($urandom_range(1)), KEY_BITS_DEF'($urandom), t_slot'($urandom),
                          1'($urandom_range(1)));
                sent++;
            end else begin
                batch_len = $urandom_range(1, 8);
                for (int b = 0; b < batch_len; b++) begin
                    case ($urandom_range(7))
                        0:       k = '0;
                        1:       k = '1;
                        2:       k = recent_key;
                        3, 4:    k = KEY_BITS_DEF'($urandom_range(127));
                        default: k = KEY_BITS_DEF'($urandom);
                    endcase
                    recent_key = k;
                    send_word(CMD_INSERT, k, t_slot'($urandom), b == batch_len - 1);
                    sent++;
                end
                reads = $urandom_range(4);
                for (int r = 0; r < reads; r++) begin
                    send_word(CMD_READ, KEY_BITS_DEF'($urandom),
                              t_slot'(($urandom_range(9) < 7) ? $urandom_range(cur_size - 1)
                                                              : $urandom_range(DEPTH_DEF - 1)),
                              1'($urandom_range(1)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_INSERT;
        key        = '0;
        slot_index = '0;
        batch_last = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_PROBE_MODE;
        cfg_data   = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: extreme keys, a duplicate, reads inside and past the table size
        send_word(CMD_INSERT, 16'h0000, 6'd0, 1'b0);
        send_word(CMD_INSERT, 16'hFFFF, 6'd63, 1'b0);
        send_word(CMD_INSERT, 16'h0000, 6'd0, 1'b0);
        send_word(CMD_READ, 16'hFFFF, 6'd0, 1'b0);
        send_word(CMD_READ, 16'h0000, 6'd63, 1'b1);
        send_word(CMD_READ, 16'h0000, 6'd10, 1'b0);
        send_word(CMD_INSERT, 16'd22, 6'd0, 1'b1);

        // size below the minimum acts as two slots, both taken: table full
        apply_settings(MODE_LINEAR, 7'd0, 4'd1, 4'd3);
        send_word(CMD_INSERT, 16'hFFFF, 6'd0, 1'b1);
        send_word(CMD_READ, 16'h0000, 6'd8, 1'b0);

        // size above the storage and the unnamed mode code
        apply_settings(MODE_SPARE, 7'd127, 4'd1, 4'd3);
        send_word(CMD_INSERT, 16'd63, 6'd0, 1'b0);
        send_word(CMD_INSERT, 16'd127, 6'd0, 1'b1);
        send_word(CMD_READ, 16'h0000, 6'd63, 1'b0);

        apply_settings(MODE_QUAD, 7'd64, 4'd15, 4'd15);
        send_word(CMD_INSERT, 16'hFFFF, 6'd0, 1'b0);
        send_word(CMD_INSERT, 16'h0000, 6'd0, 1'b0);
        send_word(CMD_INSERT, 16'd1000, 6'd0, 1'b1);

        apply_settings(MODE_DOUBLE, 7'd64, 4'd0, 4'd0);
        send_word(CMD_INSERT, 16'hFFFF, 6'd0, 1'b0);
        send_word(CMD_INSERT, 16'd4, 6'd0, 1'b1);
        send_word(CMD_READ, 16'h0000, 6'd29, 1'b0);

        for (int p = 0; p < NPHASE; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 54; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 54; end
                default: begin send_idle_pct = 24; stall_pct = 24; end
            endcase
            apply_settings(setting_mode[p], setting_size[p], setting_c1[p], setting_c2[p]);
            random_phase(PHASE_WORDS);
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
